[rtl/masked_sprite_row_blitter_assert.svh]
`ifndef MASKED_SPRITE_ROW_BLITTER_ASSERT_SVH
`define MASKED_SPRITE_ROW_BLITTER_ASSERT_SVH

// same-cycle implication
`define MSPR_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("mspr check failed");

// next-cycle implication
`define MSPR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("mspr check failed");

`endif

[rtl/mspr_pkg.sv]
`default_nettype none
package mspr_pkg;

	localparam int SCREEN_WIDTH_DEF  = 120;
	localparam int SCREEN_HEIGHT_DEF = 60;

	typedef enum logic [1:0] {
		FUNC_DRAW  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RMW,
		S_RD,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/masked_sprite_row_blitter.sv]
// Draw row: setup, then an overlapped read-modify-write of up to three bytes on the
//   framebuffer read and write ports; a row clipped wholly away skips the latter.
// Byte read: a read state; byte write, unused code: straight to the result.
// Reset (arst_n low, asynchronous) clears control state, then a clearing sweep
//   zeroes all SCREEN_HEIGHT*((SCREEN_WIDTH+3)/4) framebuffer bytes (1800 by default);
//   no beat is accepted until it ends. Items are taken one at a time.
`default_nettype none
`include "masked_sprite_row_blitter_assert.svh"
module masked_sprite_row_blitter #(
	parameter int SCREEN_WIDTH  = mspr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mspr_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// x[7:0] y[15:8] pixels[31:16] mask_bits[47:32] use_mask[48]
	// address[59:49] write_data[67:60], zero pad
	input  wire logic [71:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,   // last_row
	input  wire logic [1:0]  s_axis_tuser,   // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_data[7:0] row_visible[8], zero pad
	output logic      [15:0] m_axis_tdata
);
	import mspr_pkg::*;

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 3) / 4;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
	localparam int AW          = $clog2(STORE_BYTES);

	state_t state_q, state_d;

	logic              s_acc;
	func_t             func_in;
	logic signed [7:0] x_in, y_in;
	logic              addr_ok_in;

	func_t             func_q;
	logic [10:0]       addr_q;
	logic              addr_ok_q;
	logic signed [7:0] sprite_x_q;
	logic signed [8:0] row_cursor_q, cur_row_q, eff_row;
	logic              in_sprite_q;
	logic [15:0]       pix_q, keep_q;
	logic              masked_q;

	logic [AW-1:0]     row_base_q;
	logic              vis_q;
	logic [1:0]        j_q, wr_j_q;
	logic signed [7:0] wr_bc_q;
	logic [AW-1:0]     wr_addr_q;
	logic              wr_ok_q;

	logic signed [9:0] col_ext;
	logic              row_ok, vis_d;
	logic signed [7:0] bc;
	logic              bc_ok;
	logic [AW-1:0]     rmw_addr;

	logic              fb_we, fb_busy;
	logic [AW-1:0]     fb_waddr, fb_raddr;
	logic [7:0]        fb_wdata, fb_rdata;

	logic              m_valid_q;
	logic [15:0]       m_data_q;
	logic              out_load;

	function automatic logic [7:0] merge_byte(
		input logic [7:0]        old,
		input logic [1:0]        jm,
		input logic [1:0]        phase,
		input logic signed [7:0] bcol,
		input logic [15:0]       pix,
		input logic [15:0]       keep,
		input logic              masked
	);
		logic [7:0] nb;
		logic [1:0] pp, kk;
		int         ii, cc;
		nb = old;
		for (int p = 0; p < 4; p++) begin
			ii = 4 * int'(jm) + p - int'(phase);
			cc = 4 * int'(bcol) + p;
			if (ii >= 0 && ii < 8 && cc < SCREEN_WIDTH) begin
				pp = pix[(14 - 2 * ii) +: 2];
				kk = keep[(14 - 2 * ii) +: 2];
				nb[(6 - 2 * p) +: 2] = masked ? ((old[(6 - 2 * p) +: 2] & kk) | pp) : pp;
			end
		end
		return nb;
	endfunction

	assign func_in    = func_t'(s_axis_tuser);
	assign x_in       = s_axis_tdata[7:0];
	assign y_in       = s_axis_tdata[15:8];
	assign addr_ok_in = 32'(s_axis_tdata[59:49]) < STORE_BYTES;
	assign s_axis_tready = (state_q == S_IDLE) && !fb_busy;
	assign s_acc      = s_axis_tvalid && s_axis_tready;
	assign eff_row    = in_sprite_q ? row_cursor_q : {y_in[7], y_in};

	assign col_ext = 10'(sprite_x_q);
	assign row_ok  = !cur_row_q[8] && (cur_row_q[7:0] < 8'(SCREEN_HEIGHT));
	assign vis_d   = row_ok && (col_ext > -10'sd8) && (col_ext < $signed(10'(SCREEN_WIDTH)));

	assign bc       = (sprite_x_q >>> 2) + $signed({6'b0, j_q});
	assign bc_ok    = !bc[7] && (bc < $signed(8'(ROW_BYTES))) && (j_q != 2'd3);
	assign rmw_addr = row_base_q + AW'($unsigned(bc));

	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					unique case (func_in)
						FUNC_DRAW: state_d = S_SETUP;
						FUNC_READ: state_d = S_RD;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_SETUP: state_d = vis_d ? S_RMW : S_DONE;
			S_RMW:   if (j_q == 2'd3) state_d = S_DONE;
			S_RD:    state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sprite sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_x_q   <= '0;
			row_cursor_q <= '0;
			in_sprite_q  <= 1'b0;
		end else if (s_acc && func_in == FUNC_DRAW) begin
			if (!in_sprite_q) sprite_x_q <= x_in;
			in_sprite_q  <= !s_axis_tlast;
			row_cursor_q <= s_axis_tlast ? eff_row : eff_row + 9'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= FUNC_NOP;
			j_q    <= '0;
		end else begin
			if (s_acc) func_q <= func_in;
			if (state_q == S_RMW) j_q <= j_q + 2'd1;
			else                  j_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			addr_q    <= s_axis_tdata[59:49];
			addr_ok_q <= addr_ok_in;
			cur_row_q <= eff_row;
			pix_q     <= s_axis_tdata[31:16];
			keep_q    <= s_axis_tdata[47:32];
			masked_q  <= s_axis_tdata[48];
		end
		if (state_q == S_SETUP) begin
			row_base_q <= AW'(32'(cur_row_q[6:0]) * ROW_BYTES);
			vis_q      <= vis_d;
		end
		if (s_acc) vis_q <= 1'b0;
		wr_addr_q <= rmw_addr;
		wr_ok_q   <= (state_q == S_RMW) && bc_ok;
		wr_bc_q   <= bc;
		wr_j_q    <= j_q;
	end

	always_comb begin
		if (state_q == S_RMW) begin
			fb_we    = wr_ok_q && (j_q != 2'd0);
			fb_waddr = wr_addr_q;
			fb_wdata = merge_byte(fb_rdata, wr_j_q, sprite_x_q[1:0], wr_bc_q,
				pix_q, keep_q, masked_q);
			fb_raddr = rmw_addr;
		end else begin
			fb_we    = s_acc && (func_in == FUNC_WRITE) && addr_ok_in;
			fb_waddr = AW'(s_axis_tdata[59:49]);
			fb_wdata = s_axis_tdata[67:60];
			fb_raddr = AW'(addr_q);
		end
	end

	mspr_fb #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_fb (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.raddr (fb_raddr),
		.rdata (fb_rdata),
		.busy  (fb_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {7'b0,
				(func_q == FUNC_DRAW) && vis_q,
				((func_q == FUNC_READ) && addr_ok_q) ? fb_rdata : 8'h00};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`MSPR_ASSERT_NOW(a_no_accept_clearing, clk, arst_n, fb_busy, !s_axis_tready)
	`MSPR_ASSERT_NOW(a_fb_write_src, clk, arst_n, fb_we,
		(state_q == S_RMW) || (s_acc && func_in == FUNC_WRITE))
	`MSPR_ASSERT_NEXT(a_rmw_entry, clk, arst_n, (state_q == S_SETUP) && vis_d,
		(state_q == S_RMW) && (j_q == 2'd0))
	`MSPR_ASSERT_NOW(a_vis_only_draw, clk, arst_n, out_load && vis_q, func_q == FUNC_DRAW)

endmodule
`default_nettype wire

[rtl/mspr_fb.sv]
`default_nettype none
module mspr_fb #(
	parameter int DEPTH = 1800,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata,
	output logic               busy
);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;

	// clearing sweep after reset, one byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 8'h00;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

[bench/masked_sprite_row_blitter_checker.sv]
`timescale 1ns / 1ps
module masked_sprite_row_blitter_checker #(
	parameter int SCREEN_WIDTH  = mspr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mspr_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [71:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);
	import mspr_pkg::*;

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 3) / 4;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

	typedef struct packed {
		logic       row_visible;
		logic [7:0] read_data;
	} blit_result_t;

	logic [7:0]        fb_model [STORE_BYTES];
	logic signed [7:0] sprite_col;
	logic signed [8:0] row_cursor;
	logic              in_sprite;
	blit_result_t      blit_results_q[$];
	int                fail_total;

	// one row of the sprite at (sprite_col, row_cursor), clipped at every edge
	function automatic logic paint_row(logic [15:0] pix, logic [15:0] keep, logic masked);
		int         col0;
		int         row;
		int         c;
		int         idx;
		int         sh;
		logic [1:0] p;
		logic [1:0] k;
		logic [1:0] cur;
		logic [7:0] old;
		logic       touched;
		touched = 1'b0;
		col0 = sprite_col;
		row = row_cursor;
		if (row < 0 || row >= SCREEN_HEIGHT)
			return 1'b0;
		for (int i = 0; i < 8; i++) begin
			c = col0 + i;
			if (c >= 0 && c < SCREEN_WIDTH) begin
				touched = 1'b1;
				idx = row * ROW_BYTES + c / 4;
				p = pix[15 - 2 * i -: 2];
				k = keep[15 - 2 * i -: 2];
				sh = 6 - 2 * (c % 4);
				old = fb_model[idx];
				cur = old[sh +: 2];
				if (masked)
					cur = (cur & k) | p;
				else
					cur = p;
				old[sh +: 2] = cur;
				fb_model[idx] = old;
			end
		end
		return touched;
	endfunction

	function automatic blit_result_t predict_blit(func_t fn, logic [7:0] xi, logic [7:0] yi,
			logic [15:0] pix, logic [15:0] keep, logic masked, logic last,
			logic [10:0] addr, logic [7:0] wdata);
		blit_result_t r;
		r = '0;
		case (fn)
			FUNC_DRAW: begin
				if (!in_sprite) begin
					sprite_col = xi;
					row_cursor = {yi[7], yi};
				end
				r.row_visible = paint_row(pix, keep, masked);
				if (last) begin
					in_sprite = 1'b0;
				end else begin
					in_sprite = 1'b1;
					row_cursor = row_cursor + 9'd1;
				end
			end
			FUNC_READ: begin
				if (addr < STORE_BYTES)
					r.read_data = fb_model[addr];
			end
			FUNC_WRITE: begin
				if (addr < STORE_BYTES)
					fb_model[addr] = wdata;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		blit_result_t want;
		blit_result_t got;
		if (!arst_n) begin
			foreach (fb_model[i])
				fb_model[i] = 8'h00;
			sprite_col = '0;
			row_cursor = '0;
			in_sprite = 1'b0;
			blit_results_q.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				blit_results_q.push_back(predict_blit(func_t'(s_tuser), s_tdata[7:0],
					s_tdata[15:8], s_tdata[31:16], s_tdata[47:32], s_tdata[48], s_tlast,
					s_tdata[59:49], s_tdata[67:60]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[8:0];
				if (blit_results_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: result beat with nothing pending: read_data %02h row_visible %0d",
							$time, got.read_data, got.row_visible);
				end else begin
					want = blit_results_q.pop_front();
					if (got.read_data !== want.read_data || got.row_visible !== want.row_visible) begin
						fail_total++;
						if (fail_total <= 10)
							$display("%0t: read_data exp %02h got %02h, row_visible exp %0d got %0d",
								$time, want.read_data, got.read_data, want.row_visible,
								got.row_visible);
					end
				end
			end
			mismatches <= fail_total;
			outstanding <= blit_results_q.size();
		end
	end

endmodule

[bench/masked_sprite_row_blitter_tb.sv]
`timescale 1ns / 1ps
module masked_sprite_row_blitter_tb;
	import mspr_pkg::*;

	localparam int ROW_BYTES   = (SCREEN_WIDTH_DEF + 3) / 4;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT_DEF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	int          mismatches;
	int          outstanding;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	masked_sprite_row_blitter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	masked_sprite_row_blitter_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tlast     (s_axis_tlast),
		.s_tuser     (s_axis_tuser),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

	task automatic push_item(func_t fn, logic [7:0] xi, logic [7:0] yi, logic [15:0] pix,
			logic [15:0] keep, logic masked, logic last, logic [10:0] addr, logic [7:0] wdata);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tuser <= fn;
		s_axis_tlast <= last;
		s_axis_tdata <= {4'h0, wdata, addr, masked, keep, pix, yi, xi};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// hold off until every pending result beat has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_access();
		func_t       fn;
		int          pick;
		logic [10:0] addr;
		pick = $urandom_range(0, 19);
		if (pick < 11)
			fn = FUNC_READ;
		else if (pick < 19)
			fn = FUNC_WRITE;
		else
			fn = FUNC_NOP;
		if ($urandom_range(0, 9) < 8)
			addr = 11'($urandom_range(0, STORE_BYTES - 1));
		else
			addr = 11'($urandom_range(0, 2047));
		push_item(fn, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), 1'($urandom), addr, 8'($urandom));
	endtask

	task automatic random_sprite();
		int x0;
		int y0;
		int rows;
		int r;
		int col;
		logic last;
		if ($urandom_range(0, 9) < 7)
			x0 = int'($urandom_range(0, 139)) - 12;
		else
			x0 = int'($urandom_range(0, 255)) - 128;
		if ($urandom_range(0, 9) < 7)
			y0 = int'($urandom_range(0, 75)) - 8;
		else
			y0 = int'($urandom_range(0, 255)) - 128;
		if ($urandom_range(0, 19) == 0)
			rows = $urandom_range(11, 48);
		else
			rows = $urandom_range(1, 10);
		for (int i = 0; i < rows; i++) begin
			if ($urandom_range(0, 9) == 0)
				random_access();
			// now and then leave the sprite open so the next one runs on
			last = (i == rows - 1) && ($urandom_range(0, 19) != 0);
			if (i == 0)
				push_item(FUNC_DRAW, 8'(x0), 8'(y0), 16'($urandom), 16'($urandom),
					1'($urandom), last, 11'($urandom), 8'($urandom));
			else
				push_item(FUNC_DRAW, 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom), last, 11'($urandom), 8'($urandom));
		end
		if ($urandom_range(0, 1)) begin
			r = y0 + int'($urandom_range(0, rows - 1));
			col = x0 + int'($urandom_range(0, 7));
			if (r >= 0 && r < SCREEN_HEIGHT_DEF && col >= 0 && col < SCREEN_WIDTH_DEF)
				push_item(FUNC_READ, 8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom),
					11'(r * ROW_BYTES + col / 4), 8'($urandom));
		end
	endtask

	initial begin
		int goal;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		s_axis_tuser <= FUNC_NOP;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// byte access at the store edges and beyond it
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'(STORE_BYTES - 1), 0);
		push_item(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0, 8'ha5);
		push_item(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 11'(STORE_BYTES - 1), 8'hff);
		push_item(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 11'(STORE_BYTES), 8'h5a);
		push_item(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 11'h7ff, 8'hff);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'(STORE_BYTES - 1), 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'(STORE_BYTES), 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'h7ff, 0);
		push_item(FUNC_NOP, 8'hff, 8'hff, 16'hffff, 16'hffff, 1, 1, 11'h7ff, 8'hff);

		// single-row sprites on and off every edge
		push_item(FUNC_DRAW, 8'(-128), 8'(-128), 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 0, 0, 16'hffff, 16'h0000, 1, 1, 0, 0);
		push_item(FUNC_DRAW, 8'(-7), 1, 16'h5555, 16'hffff, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 8'(-8), 2, 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 119, 59, 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 120, 3, 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 127, 4, 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 112, 60, 16'hffff, 16'h0000, 0, 1, 0, 0);
		push_item(FUNC_DRAW, 3, 127, 16'hffff, 16'h0000, 0, 1, 0, 0);

		// three rows from above the top edge, x and y ignored after the first
		push_item(FUNC_DRAW, 2, 8'(-1), 16'h1111, 16'haaaa, 1, 0, 0, 0);
		push_item(FUNC_DRAW, 8'h7f, 8'h7f, 16'h1b1b, 16'haaaa, 1, 0, 0, 0);
		push_item(FUNC_DRAW, 8'h80, 8'h80, 16'h0000, 16'hffff, 1, 1, 0, 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'(ROW_BYTES), 0);
		push_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 11'(ROW_BYTES + 2), 0);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 68; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 68; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			goal = items_sent + 160;
			while (items_sent < goal) begin
				if ($urandom_range(0, 9) < 6)
					random_sprite();
				else
					random_access();
			end
			settle();
		end

		idle_pct = 0;
		stall_pct = 0;
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("masked_sprite_row_blitter_tb: clean");
		else
			$display("masked_sprite_row_blitter_tb: errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("masked_sprite_row_blitter_tb: errors");
		$finish;
	end

endmodule

[masked_sprite_row_blitter.f]
+incdir+rtl
rtl/mspr_pkg.sv
rtl/mspr_fb.sv
rtl/masked_sprite_row_blitter.sv
bench/masked_sprite_row_blitter_checker.sv
bench/masked_sprite_row_blitter_tb.sv
